>>> hw/rtl/dowf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dowf_pkg
// Types and constants shared by the overlap window framer modules.
// ----------------------------------------------------------------------------
package dowf_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TAKE  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef struct packed {
    req_e               req_type;
    logic signed [15:0] sample;
    logic        [7:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic              window_ready;
    logic        [1:0] completed_id;
    logic              done_now;
    logic signed [7:0] read_data;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    req_e       kind;
    logic       pick;
    logic [7:0] value;
    logic [7:0] read_index;
  } cmd_t;

  localparam int unsigned CmdqDepth = 2;
  localparam int unsigned HalfStart = 2;
  localparam int unsigned HalfStep  = 11;

endpackage
`default_nettype wire

>>> hw/rtl/dowf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dowf_front
// Tracks the sample position within a block and the decimated pick position,
// and turns each accepted item into a command for the back end.
// ----------------------------------------------------------------------------
module dowf_front #(
  parameter int unsigned RECORD_BYTES = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire dowf_pkg::in_item_t item_i,
  output dowf_pkg::cmd_t         cmd_o
);

  localparam int unsigned SamplesPerBlock = RECORD_BYTES / 2;
  localparam int unsigned SW = $clog2(SamplesPerBlock);
  localparam int unsigned HW = $clog2(2 * RECORD_BYTES + 32);

  logic [SW-1:0] sib_q;
  logic [HW-1:0] half_q;
  logic [HW-2:0] byte_pos;
  logic [HW-2:0] pick_pos;
  logic [HW-2:0] hi_byte;
  logic          match;

  always_comb begin
    byte_pos = half_q[HW-1:1];
    pick_pos = byte_pos[0] ? byte_pos : byte_pos - 1'b1;
    hi_byte  = (HW-1)'({sib_q, 1'b1});
    match    = (pick_pos == hi_byte);
  end

  always_comb begin
    cmd_o.kind       = item_i.req_type;
    cmd_o.pick       = match;
    cmd_o.value      = item_i.sample[15:8];
    cmd_o.read_index = item_i.read_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sib_q  <= '0;
      half_q <= HW'(dowf_pkg::HalfStart);
    end else if (accept_i && item_i.req_type == dowf_pkg::REQ_PUSH) begin
      if (sib_q == SW'(SamplesPerBlock - 1)) begin
        sib_q  <= '0;
        half_q <= HW'(dowf_pkg::HalfStart);
      end else begin
        sib_q <= sib_q + 1'b1;
        if (match) begin
          half_q <= half_q + HW'(dowf_pkg::HalfStep);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dowf_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dowf_cmd_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module dowf_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dowf_pkg::cmd_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output dowf_pkg::cmd_t      data_o,
  output logic                empty_o
);

  localparam int unsigned PW = $clog2(dowf_pkg::CmdqDepth);
  localparam int unsigned CW = $clog2(dowf_pkg::CmdqDepth + 1);

  dowf_pkg::cmd_t mem_q [dowf_pkg::CmdqDepth];
  logic [PW-1:0]  wr_ptr_q;
  logic [PW-1:0]  rd_ptr_q;
  logic [CW-1:0]  count_q;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (count_q == CW'(dowf_pkg::CmdqDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(dowf_pkg::CmdqDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(dowf_pkg::CmdqDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dowf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dowf_back
// Executes commands on the window store: writes picks, copies the overlap,
// serves reads, clears the store, and holds the result register.
// ----------------------------------------------------------------------------
module dowf_back #(
  parameter int unsigned WINDOW_LEN  = 256,
  parameter int unsigned HOP_LEN     = 128,
  parameter int unsigned NUM_WINDOWS = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dowf_pkg::cmd_t cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  output dowf_pkg::out_item_t res_o,
  output logic                res_valid_o,
  input  wire logic           res_pop_i,
  output logic                init_busy_o
);

  localparam int unsigned OverlapLen = (HOP_LEN < WINDOW_LEN) ? (WINDOW_LEN - HOP_LEN) : 0;
  localparam int unsigned Depth = NUM_WINDOWS * WINDOW_LEN;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned PW = $clog2(WINDOW_LEN + 1);
  localparam int unsigned WW = $clog2(NUM_WINDOWS);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_CLEAR
  } state_e;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  state_e              state_q;
  logic [CW-1:0]       cnt_q;
  logic [WW-1:0]       ww_q;
  logic [PW-1:0]       wpos_q;
  logic                cv_q;
  logic [WW-1:0]       cw_q;
  logic                res_valid_q;
  dowf_pkg::out_item_t res_q;
  logic [AW-1:0]       cp_src_q;
  logic [AW-1:0]       cp_dst_q;
  logic [AW-1:0]       cp_wdst_q;
  logic                wr_pend_q;

  logic          idle_go;
  logic          fill_done;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [WW-1:0] ww_next;
  logic [WW-1:0] rd_win;
  logic          rd_in_range;
  logic [AW-1:0] wbase;

  assign idle_go     = (state_q == ST_IDLE) && !cmd_empty_i && !res_valid_q && !wr_pend_q;
  assign fill_done   = idle_go && (cmd_i.kind == dowf_pkg::REQ_PUSH) && cmd_i.pick &&
                       (wpos_q == PW'(WINDOW_LEN - 1));
  assign cmd_pop_o   = idle_go;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;
  assign init_busy_o = (state_q == ST_INIT);
  assign ww_next     = (ww_q == WW'(NUM_WINDOWS - 1)) ? '0 : ww_q + 1'b1;
  assign rd_win      = cv_q ? cw_q : '0;
  assign rd_in_range = (32'(cmd_i.read_index) < WINDOW_LEN);
  assign wbase       = AW'(32'(ww_q) * WINDOW_LEN);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (wr_pend_q) begin
      we    = 1'b1;
      waddr = cp_wdst_q;
      wdata = rdata_q;
    end else if (state_q == ST_INIT || state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = cnt_q[AW-1:0];
    end else if (idle_go && cmd_i.kind == dowf_pkg::REQ_PUSH && cmd_i.pick) begin
      we    = 1'b1;
      waddr = wbase + AW'(wpos_q);
      wdata = cmd_i.value;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = cp_src_q;
    if (state_q == ST_COPY) begin
      re = 1'b1;
    end else if (idle_go && cmd_i.kind == dowf_pkg::REQ_READ && rd_in_range) begin
      re    = 1'b1;
      raddr = AW'(32'(rd_win) * WINDOW_LEN + 32'(cmd_i.read_index));
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      ww_q        <= '0;
      wpos_q      <= '0;
      cv_q        <= 1'b0;
      cw_q        <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      cp_src_q    <= '0;
      cp_dst_q    <= '0;
      cp_wdst_q   <= '0;
      wr_pend_q   <= 1'b0;
    end else begin
      wr_pend_q <= (state_q == ST_COPY);
      cp_wdst_q <= cp_dst_q;
      if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT, ST_CLEAR: begin
          if (cnt_q == CW'(Depth - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (idle_go) begin
            res_q.window_ready <= cv_q;
            res_q.completed_id <= 2'(fill_done ? ww_q : cw_q);
            res_q.done_now     <= fill_done;
            res_q.read_data    <= '0;
            res_valid_q        <= !(cmd_i.kind == dowf_pkg::REQ_READ && rd_in_range);
            case (cmd_i.kind)
              dowf_pkg::REQ_PUSH: begin
                if (cmd_i.pick) begin
                  if (fill_done) begin
                    cv_q   <= 1'b1;
                    cw_q   <= ww_q;
                    ww_q   <= ww_next;
                    wpos_q <= PW'(OverlapLen);
                    if (OverlapLen > 0) begin
                      cp_src_q <= wbase + AW'(WINDOW_LEN - OverlapLen);
                      cp_dst_q <= AW'(32'(ww_next) * WINDOW_LEN);
                      cnt_q    <= '0;
                      state_q  <= ST_COPY;
                    end
                  end else begin
                    wpos_q <= wpos_q + 1'b1;
                  end
                end
              end
              dowf_pkg::REQ_READ: begin
                if (rd_in_range) begin
                  state_q <= ST_READ;
                end
              end
              dowf_pkg::REQ_TAKE: begin
                cv_q <= 1'b0;
              end
              dowf_pkg::REQ_CLEAR: begin
                cv_q    <= 1'b0;
                cnt_q   <= '0;
                state_q <= ST_CLEAR;
              end
              default: begin
                cv_q <= cv_q;
              end
            endcase
          end
        end
        ST_READ: begin
          res_q.read_data <= rdata_q;
          res_valid_q     <= 1'b1;
          state_q         <= ST_IDLE;
        end
        ST_COPY: begin
          cp_src_q <= cp_src_q + 1'b1;
          cp_dst_q <= cp_dst_q + 1'b1;
          if (cnt_q == CW'(OverlapLen - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/decimating_overlap_window_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimating_overlap_window_framer
// Picks every 5.5th byte of 16-bit audio blocks into overlapping windows.
// ----------------------------------------------------------------------------
// Usage: requests enter through a queue-style port (push/full, in_item_i) and
// results leave through one (empty/pop, out_item_o), one result per request.
// A front end classifies each request and tracks the pick position, a
// two-entry command queue decouples it from the back end, which owns the
// single-port-write, single-port-read window memory.
// Flow: a push, take or clear result is registered once its command leaves the
// command queue; a read result first passes the registered memory read. The
// back end takes no new command until the previous result is popped.
// A push that fills a window adds an overlap copy of WINDOW_LEN-HOP_LEN bytes,
// one byte per cycle through the memory port; a clear zeroes all
// NUM_WINDOWS*WINDOW_LEN entries, one entry a cycle.
// Reset: a clearing pass over all NUM_WINDOWS*WINDOW_LEN entries zeroes the memory;
// full stays high until it ends.
// Stall: while the result is not popped the back end holds, the command
// queue fills and full rises; no item is lost or repeated.
// ----------------------------------------------------------------------------
module decimating_overlap_window_framer #(
  parameter int unsigned RECORD_BYTES = 256,
  parameter int unsigned WINDOW_LEN   = 256,
  parameter int unsigned HOP_LEN      = 128,
  parameter int unsigned NUM_WINDOWS  = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire dowf_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output dowf_pkg::out_item_t      out_item_o
);

  dowf_pkg::cmd_t front_cmd;
  dowf_pkg::cmd_t back_cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           accept;
  logic           init_busy;
  logic           res_valid;

  assign full   = q_full || init_busy;
  assign accept = push && !full;
  assign empty  = !res_valid;

  dowf_front #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .cmd_o   (front_cmd)
  );

  dowf_cmd_fifo u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (front_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (back_cmd),
    .empty_o(q_empty)
  );

  dowf_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .HOP_LEN    (HOP_LEN),
    .NUM_WINDOWS(NUM_WINDOWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (back_cmd),
    .cmd_empty_i(q_empty),
    .cmd_pop_o  (q_pop),
    .res_o      (out_item_o),
    .res_valid_o(res_valid),
    .res_pop_i  (pop),
    .init_busy_o(init_busy)
  );

endmodule
`default_nettype wire
